// File: rtl/indexed_list_insert_delete_macros.svh
// Assertion macros used by the indexed list datapath.
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

`ifndef ASSERT_OFF

// Plain invariant, checked every clock outside reset.
`define ILID_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ILID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ILID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ILID_ASSERT(label, expr, msg)
`define ILID_ASSERT_IMP(label, ante, cons, msg)
`define ILID_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/ilid_pkg.sv
// Shared types and codes for the indexed list block.
`timescale 1ns / 1ps

package ilid_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic put;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic is_insert;
    logic moves_done;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/indexed_list_insert_delete.sv
// Top level of the indexed list: ordered store of signed 32-bit words with insert and delete.
`timescale 1ns / 1ps

// Keeps up to DEPTH signed 32-bit values in order, entry 0 at the head, in one
// RAM. An insert word (op 0) places value at 0-based position index and moves
// later entries up; a delete word (op 1) removes the entry at 1-based position
// index, moves later entries down and returns its value. Every input word gives
// exactly one result word with removed_value (zero unless a delete succeeded),
// status (0 ok, 1 position out of range, 2 store full; position is checked
// before fullness) and the list length after the operation. A rejected word
// leaves the list unchanged. One item is worked at a time: ready stays low from
// the accepting edge until the result is committed. A good delete, or a good
// insert that has to move entries, takes longer the more entries lie beyond
// its position, and any result may wait for the output register to drain.
// The cost is set by the single RAM port pair, which moves one entry per
// cycle. The RAM needs no clearing after reset: only positions below the
// current length are ever read.
module indexed_list_insert_delete #(
  parameter int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH + 1),
  localparam int IN_TDATA_W = ((1 + IDX_W + 32 + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((32 + 2 + IDX_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // op, index, value, zero fill
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // removed_value, status, length, zero fill
);

  ilid_pkg::cmd_t  cmd;
  ilid_pkg::stat_t stat;

  logic [ilid_pkg::VALUE_W-1:0]  out_removed;
  logic [ilid_pkg::STATUS_W-1:0] out_status;
  logic [IDX_W-1:0]              out_length;

  // Controller: walks each word through check, shift, write and report.
  ilid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: unpack the input word straight into the item registers.
  ilid_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (s_tdata[0]),
    .in_index    (s_tdata[IDX_W:1]),
    .in_value    (s_tdata[IDX_W+32:IDX_W+1]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_removed (out_removed),
    .out_status  (out_status),
    .out_length  (out_length)
  );

  // Pack the result word, first field lowest, zero fill on top.
  assign m_tdata = OUT_TDATA_W'({out_length, out_status, out_removed});

endmodule

// File: rtl/ilid_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ilid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ilid_ctrl.sv
// Sequencer for the indexed list: accept, check, shift, write, report.
`timescale 1ns / 1ps

module ilid_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  ilid_pkg::stat_t stat,
  output ilid_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_MOVE   = 5'b00100,
    S_WRITE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.err ? S_FINISH : S_MOVE;
      end
      S_MOVE: begin
        cmd.step = 1'b1;
        if (stat.moves_done) begin
          state_next = stat.is_insert ? S_WRITE : S_FINISH;
        end
      end
      S_WRITE: begin
        cmd.put    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/ilid_dp.sv
// Datapath for the indexed list: item registers, length, shift engine, result register.
`timescale 1ns / 1ps
`include "indexed_list_insert_delete_macros.svh"

module ilid_dp #(
  parameter int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH + 1),
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ilid_pkg::cmd_t                cmd,
  output ilid_pkg::stat_t               stat,
  input  logic                          in_op,
  input  logic [IDX_W-1:0]              in_index,
  input  logic [ilid_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ilid_pkg::VALUE_W-1:0]  out_removed,
  output logic [ilid_pkg::STATUS_W-1:0] out_status,
  output logic [IDX_W-1:0]              out_length
);

  localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(DEPTH);
  localparam logic [IDX_W-1:0] ONE_C   = IDX_W'(1);
  localparam logic [AW-1:0]    ONE_A   = AW'(1);

  ilid_pkg::op_t              op_q;
  logic [IDX_W-1:0]           idx_q;
  logic [ilid_pkg::VALUE_W-1:0] value_q;
  logic [IDX_W-1:0]           count;
  logic [IDX_W-1:0]           rem;
  logic [AW-1:0]              cur;
  logic [AW-1:0]              last_addr;
  logic                       rd_pend;
  logic                       first_q;
  ilid_pkg::status_t          status_q;
  logic [ilid_pkg::VALUE_W-1:0] removed;

  logic                       ins;
  ilid_pkg::status_t          chk_status;
  logic [IDX_W-1:0]           cnt_m1;
  logic [IDX_W-1:0]           idx_m1;
  logic [IDX_W-1:0]           count_new;
  logic                       rd_en;
  logic                       mv_wr;
  logic [AW-1:0]              mv_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ilid_pkg::VALUE_W-1:0] wr_data;
  logic [ilid_pkg::VALUE_W-1:0] rd_data;

  assign ins    = (op_q == ilid_pkg::OP_INSERT);
  assign cnt_m1 = count - ONE_C;
  assign idx_m1 = idx_q - ONE_C;

  // position is checked before fullness
  always_comb begin
    chk_status = ilid_pkg::ST_OK;
    if (ins) begin
      if (idx_q > count) begin
        chk_status = ilid_pkg::ST_RANGE;
      end else if (count == DEPTH_C) begin
        chk_status = ilid_pkg::ST_FULL;
      end
    end else if (idx_q == '0 || idx_q > count) begin
      chk_status = ilid_pkg::ST_RANGE;
    end
  end

  always_comb begin
    count_new = count;
    if (status_q == ilid_pkg::ST_OK) begin
      count_new = ins ? count + ONE_C : count - ONE_C;
    end
  end

  // one read per step while entries remain; the data lands in the next cycle and
  // is written one slot up (insert) or down (delete), except the entry a delete removes
  assign rd_en   = cmd.step && (rem != '0);
  assign mv_wr   = cmd.step && rd_pend && !first_q;
  assign mv_addr = ins ? last_addr + ONE_A : last_addr - ONE_A;
  assign wr_en   = mv_wr || cmd.put;
  assign wr_addr = cmd.put ? idx_q[AW-1:0] : mv_addr;
  assign wr_data = cmd.put ? value_q : rd_data;

  ilid_ram #(
    .WIDTH (ilid_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cur),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rem       <= '0;
      rd_pend   <= 1'b0;
      first_q   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_q    <= ilid_pkg::op_t'(in_op);
        idx_q   <= in_index;
        value_q <= in_value;
      end
      if (cmd.eval) begin
        status_q <= chk_status;
        removed  <= '0;
        first_q  <= !ins;
        rd_pend  <= 1'b0;
        cur      <= ins ? cnt_m1[AW-1:0] : idx_m1[AW-1:0];
        if (chk_status == ilid_pkg::ST_OK) begin
          rem <= ins ? count - idx_q : count - idx_q + ONE_C;
        end else begin
          rem <= '0;
        end
      end
      if (cmd.step) begin
        rd_pend <= rem != '0;
        if (rem != '0) begin
          cur       <= ins ? cur - ONE_A : cur + ONE_A;
          last_addr <= cur;
          rem       <= rem - ONE_C;
        end
        if (rd_pend && first_q) begin
          removed <= rd_data;
          first_q <= 1'b0;
        end
      end
      if (cmd.commit) begin
        count       <= count_new;
        out_valid   <= 1'b1;
        out_removed <= removed;
        out_status  <= status_q;
        out_length  <= count_new;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.err        = (chk_status != ilid_pkg::ST_OK);
  assign stat.is_insert  = ins;
  assign stat.moves_done = (rem == '0) && !rd_pend;
  assign stat.out_free   = !out_valid || out_ready;

  `ILID_ASSERT(a_count_bound, count <= DEPTH_C, "list length above depth")
  `ILID_ASSERT_IMP(a_put_ok_insert, cmd.put, ins && status_q == ilid_pkg::ST_OK, "value write outside good insert")
  `ILID_ASSERT_IMP(a_commit_drained, cmd.commit, rem == '0 && !rd_pend, "result committed with shift in flight")
  `ILID_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid && out_length == count, "reported length differs from stored length")

endmodule
